>>> hw/rtl/keypad_scan_debounce_fifo_macros.svh
// assertion macros shared by the keypad scanner rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef KEYPAD_SCAN_DEBOUNCE_FIFO_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_FIFO_MACROS_SVH

`ifndef ASSERT_OFF
`define KPSD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KPSD_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define KPSD_ASSERT(name, prop, msg)
`define KPSD_NEVER(name, cond, msg)
`endif

`endif

>>> hw/rtl/kpsd_pkg.sv
// shared constants, codes and structs of the keypad scanner
// no dependencies
package kpsd_pkg;

	localparam int ROWS       = 4;
	localparam int COLS       = 4;
	localparam int FIFO_DEPTH = 16;

	localparam int LINES_W    = 16;
	localparam int KEY_W      = 8;
	localparam int ACTION_W   = 2;
	localparam int MAP_W      = 2;
	localparam int RCNT_W     = 3;
	localparam int CNT_W      = 16;
	localparam int LIMIT_W    = 5;
	localparam int STATUS_W   = 1;

	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W      = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int TBL_DEPTH  = ROWS * COLS;
	localparam int TBL_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
	localparam int DIM_W      = 4;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_POLL   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_ASSIGN = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_SCAN_ROWS      = 2'd0,
		REG_SCAN_COLS      = 2'd1,
		REG_DEBOUNCE_LIMIT = 2'd2,
		REG_KEY_LIMIT      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [RCNT_W-1:0]  scan_rows;
		logic [RCNT_W-1:0]  scan_cols;
		logic [CNT_W-1:0]   debounce_limit;
		logic [LIMIT_W-1:0] key_limit;
	} cfg_t;

	typedef struct packed {
		logic             found;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} scan_hit_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [KEY_W-1:0] push_data;
	} fifo_ctrl_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [KEY_W-1:0]  head_data;
	} fifo_stat_t;

endpackage

>>> hw/rtl/kpsd_req_if.sv
// request channel of the keypad scanner: valid/ready plus item fields
// depends on kpsd_pkg
interface kpsd_req_if
	import kpsd_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [LINES_W-1:0]  matrix_lines;
	logic [MAP_W-1:0]    map_row;
	logic [MAP_W-1:0]    map_col;
	logic [KEY_W-1:0]    map_key;

	modport source (
		output valid, action, matrix_lines, map_row, map_col, map_key,
		input  ready
	);
	modport sink (
		input  valid, action, matrix_lines, map_row, map_col, map_key,
		output ready
	);
endinterface

>>> hw/rtl/kpsd_rsp_if.sv
// response channel of the keypad scanner: valid/ready plus result fields
// depends on kpsd_pkg
interface kpsd_rsp_if
	import kpsd_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    key_code;
	logic [FILL_W-1:0]   key_count;

	modport source (
		output valid, status, key_code, key_count,
		input  ready
	);
	modport sink (
		input  valid, status, key_code, key_count,
		output ready
	);
endinterface

>>> hw/rtl/kpsd_cfg_regs.sv
// apb configuration registers of the keypad scanner
// depends on kpsd_pkg
module kpsd_cfg_regs
	import kpsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	cfg_reg_t reg_sel;
	logic     wr_en;

	assign reg_sel = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_rows      <= RCNT_W'(4);
			cfg_q.scan_cols      <= RCNT_W'(4);
			cfg_q.debounce_limit <= CNT_W'(10);
			cfg_q.key_limit      <= LIMIT_W'(16);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_SCAN_ROWS:      cfg_q.scan_rows      <= pwdata[RCNT_W-1:0];
				REG_SCAN_COLS:      cfg_q.scan_cols      <= pwdata[RCNT_W-1:0];
				REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= pwdata[CNT_W-1:0];
				REG_KEY_LIMIT:      cfg_q.key_limit      <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_SCAN_ROWS:      prdata = APB_DATA_W'(cfg_q.scan_rows);
			REG_SCAN_COLS:      prdata = APB_DATA_W'(cfg_q.scan_cols);
			REG_DEBOUNCE_LIMIT: prdata = APB_DATA_W'(cfg_q.debounce_limit);
			REG_KEY_LIMIT:      prdata = APB_DATA_W'(cfg_q.key_limit);
			default:            prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/kpsd_scan.sv
// matrix scan: first pressed key, columns outer and rows inner
// depends on kpsd_pkg
module kpsd_scan
	import kpsd_pkg::*;
(
	input  logic [LINES_W-1:0] lines,
	input  cfg_t               cfg,
	output scan_hit_t          hit
);

	logic [DIM_W-1:0] nrow;
	logic [DIM_W-1:0] ncol;

	assign nrow = (int'(cfg.scan_rows) > ROWS) ? DIM_W'(ROWS) : DIM_W'(cfg.scan_rows);
	assign ncol = (int'(cfg.scan_cols) > COLS) ? DIM_W'(COLS) : DIM_W'(cfg.scan_cols);

	// walk from the highest position down so the lowest pressed one wins
	always_comb begin
		hit = '0;
		for (int c = COLS - 1; c >= 0; c--) begin
			for (int r = ROWS - 1; r >= 0; r--) begin
				if ((c * ROWS + r) < LINES_W && c < int'(ncol) && r < int'(nrow)
						&& lines[(c * ROWS + r) % LINES_W]) begin
					hit.found = 1'b1;
					hit.row   = ROW_W'(r);
					hit.col   = COL_W'(c);
				end
			end
		end
	end

endmodule

>>> hw/rtl/kpsd_key_fifo.sv
// circular key fifo with fill count, one push or one pop per cycle
// depends on kpsd_pkg and the assertion macros
`include "keypad_scan_debounce_fifo_macros.svh"
module kpsd_key_fifo
	import kpsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_ctrl_t ctrl,
	output fifo_stat_t stat
);

	logic [KEY_W-1:0]  mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [FILL_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[tail_q] <= ctrl.push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= ptr_inc(tail_q);
				fill_q <= FILL_W'(fill_q + 1'b1);
			end else if (ctrl.pop) begin
				head_q <= ptr_inc(head_q);
				fill_q <= FILL_W'(fill_q - 1'b1);
			end
		end
	end

	assign stat.fill      = fill_q;
	assign stat.head_data = mem_q[head_q];

	`KPSD_NEVER(a_fill_range, int'(fill_q) > FIFO_DEPTH, "fifo fill above depth")
	`KPSD_ASSERT(a_push_count, ctrl.push |=> fill_q == FILL_W'($past(fill_q) + 1'b1), "push did not raise fill")
	`KPSD_ASSERT(a_empty_ptrs, (fill_q == '0) |-> (head_q == tail_q), "empty fifo with split pointers")
	`KPSD_NEVER(a_pop_empty, ctrl.pop && (fill_q == '0), "pop from empty fifo")

endmodule

>>> hw/rtl/keypad_scan_debounce_fifo.sv
// top level of the keypad matrix scanner with debounce and key fifo
// depends on kpsd_pkg, kpsd_req_if, kpsd_rsp_if, kpsd_cfg_regs, kpsd_scan, kpsd_key_fifo
//
// channel  dir  handshake        fields
// req      in   valid / ready    action, matrix_lines, map_row, map_col, map_key
// rsp      out  valid / ready    status, key_code, key_count
// apb      in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
// one item per cycle while rsp is not stalled; an item passes the input register,
// then the result register, which drives rsp
// the state update (table, counter, fifo) happens as an item leaves the input register
// a stalled rsp holds the result register and backs up into the input register
// arst_n clears control state and the key table, not the data registers; no clearing pass
`include "keypad_scan_debounce_fifo_macros.svh"
module keypad_scan_debounce_fifo
	import kpsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	kpsd_req_if.sink              req,
	kpsd_rsp_if.source            rsp
);

	cfg_t       cfg;
	scan_hit_t  hit;
	fifo_ctrl_t fifo_ctrl;
	fifo_stat_t fifo_stat;

	// input register
	logic                s1_valid_q;
	logic [ACTION_W-1:0] action_s1;
	logic [LINES_W-1:0]  lines_s1;
	logic [MAP_W-1:0]    map_row_s1;
	logic [MAP_W-1:0]    map_col_s1;
	logic [KEY_W-1:0]    map_key_s1;

	// result register
	logic                s2_valid_q;
	logic [STATUS_W-1:0] status_s2;
	logic [KEY_W-1:0]    key_code_s2;
	logic [FILL_W-1:0]   key_count_s2;

	logic [KEY_W-1:0]    key_table_q [TBL_DEPTH];
	logic [CNT_W-1:0]    bounce_q;

	logic                s1_adv;
	action_t             act;
	logic [FILL_W-1:0]   limit_eff;
	logic                poll_blocked;
	logic [CNT_W-1:0]    bounce_inc;
	logic [CNT_W-1:0]    bounce_d;
	logic [TBL_W-1:0]    hit_idx;
	logic [TBL_W-1:0]    map_idx;
	logic                tbl_we;
	logic                push;
	logic                pop;
	logic [STATUS_W-1:0] status_d;
	logic [KEY_W-1:0]    key_code_d;
	logic [FILL_W-1:0]   count_d;

	kpsd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kpsd_scan u_scan (
		.lines (lines_s1),
		.cfg   (cfg),
		.hit   (hit)
	);

	kpsd_key_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fifo_ctrl),
		.stat   (fifo_stat)
	);

	assign s1_adv    = s1_valid_q && (!s2_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_adv;
	assign act       = action_t'(action_s1);

	assign limit_eff    = (int'(cfg.key_limit) > FIFO_DEPTH) ? FILL_W'(FIFO_DEPTH)
	                                                         : FILL_W'(cfg.key_limit);
	assign poll_blocked = fifo_stat.fill >= limit_eff;
	assign bounce_inc   = (bounce_q == '1) ? bounce_q : CNT_W'(bounce_q + 1'b1);
	assign hit_idx      = TBL_W'(TBL_W'(hit.row) * TBL_W'(COLS) + TBL_W'(hit.col));
	assign map_idx      = TBL_W'(TBL_W'(map_row_s1) * TBL_W'(COLS) + TBL_W'(map_col_s1));

	always_comb begin
		bounce_d   = bounce_q;
		tbl_we     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		status_d   = '0;
		key_code_d = '0;
		unique case (act)
			ACT_POLL: begin
				if (!poll_blocked) begin
					if (hit.found) begin
						bounce_d = bounce_inc;
						push     = bounce_inc >= cfg.debounce_limit;
					end else begin
						bounce_d = '0;
					end
				end
			end
			ACT_POP: begin
				if (fifo_stat.fill == '0) begin
					status_d = STATUS_W'(1);
				end else begin
					pop        = 1'b1;
					key_code_d = fifo_stat.head_data;
				end
			end
			ACT_ASSIGN: begin
				tbl_we = (int'(map_row_s1) < ROWS) && (int'(map_col_s1) < COLS);
			end
			default: ;
		endcase
		count_d = FILL_W'(fifo_stat.fill + FILL_W'(push) - FILL_W'(pop));
	end

	assign fifo_ctrl.push      = s1_adv && push;
	assign fifo_ctrl.pop       = s1_adv && pop;
	assign fifo_ctrl.push_data = key_table_q[hit_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			bounce_q   <= '0;
			for (int i = 0; i < TBL_DEPTH; i++) begin
				key_table_q[i] <= '0;
			end
		end else begin
			if (req.ready) begin
				s1_valid_q <= req.valid;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
				bounce_q   <= bounce_d;
				if (tbl_we) begin
					key_table_q[map_idx] <= map_key_s1;
				end
			end else if (rsp.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1  <= req.action;
			lines_s1   <= req.matrix_lines;
			map_row_s1 <= req.map_row;
			map_col_s1 <= req.map_col;
			map_key_s1 <= req.map_key;
		end
		if (s1_adv) begin
			status_s2    <= status_d;
			key_code_s2  <= key_code_d;
			key_count_s2 <= count_d;
		end
	end

	assign rsp.valid     = s2_valid_q;
	assign rsp.status    = status_s2;
	assign rsp.key_code  = key_code_s2;
	assign rsp.key_count = key_count_s2;

	`KPSD_ASSERT(a_err_empty, (s2_valid_q && status_s2 != '0) |-> (key_code_s2 == '0 && key_count_s2 == '0), "error result with data")
	`KPSD_ASSERT(a_full_hold, (s1_adv && act == ACT_POLL && poll_blocked) |=> $stable(bounce_q), "full poll changed counter")
	`KPSD_ASSERT(a_stall_src, !req.ready |-> (s1_valid_q && s2_valid_q), "stall without full pipeline")
	`KPSD_ASSERT(a_count_match, s1_adv |=> (key_count_s2 == fifo_stat.fill), "result count differs from fifo fill")

endmodule
